/* hdl/fti_pkg.sv */
// Shared types and constants of the escape-time fractal iterator.
// Holds the sequencer state type, mode codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fti_pkg;

	// Sequencer states of the iteration core
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CROSS,
		ST_UPDATE,
		ST_DONE
	} fti_state_t;

	// Fractal mode codes; the fourth code runs as Mandelbrot
	localparam int unsigned MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

	// Register indexes on the configuration port
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MODE       = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_JULIA_REAL = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_JULIA_IMAG = 2'd3;

endpackage

`default_nettype wire

/* hdl/fti_regs.sv */
// APB-style configuration register file of the fractal iterator.
// Depends on fti_pkg for register indexes and mode width.
`timescale 1ns / 1ps
`default_nettype none

module fti_regs
	import fti_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int COUNT_WIDTH = 16,
	parameter int DATA_WIDTH  = 32,
	parameter int ADDR_WIDTH  = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ADDR_WIDTH-1:0]         paddr,
	input  wire logic [DATA_WIDTH-1:0]         pwdata,
	output logic      [DATA_WIDTH-1:0]         prdata,
	output logic                               pready,
	output logic      [MODE_W-1:0]             mode_q,
	output logic      [COUNT_WIDTH-1:0]        limit_q,
	output logic signed [COORD_WIDTH-1:0]      julia_real_q,
	output logic signed [COORD_WIDTH-1:0]      julia_imag_q
);

	// register index sits just above the byte offset
	localparam int unsigned IDX_LSB = ADDR_WIDTH - REG_IDX_W;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[ADDR_WIDTH-1:IDX_LSB];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_MANDEL;
			limit_q      <= COUNT_WIDTH'(64);
			julia_real_q <= '0;
			julia_imag_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:       mode_q       <= pwdata[MODE_W-1:0];
				REG_LIMIT:      limit_q      <= pwdata[COUNT_WIDTH-1:0];
				REG_JULIA_REAL: julia_real_q <= pwdata[COORD_WIDTH-1:0];
				REG_JULIA_IMAG: julia_imag_q <= pwdata[COORD_WIDTH-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODE:       prdata[MODE_W-1:0]      = mode_q;
			REG_LIMIT:      prdata[COUNT_WIDTH-1:0] = limit_q;
			REG_JULIA_REAL: prdata[COORD_WIDTH-1:0] = julia_real_q;
			REG_JULIA_IMAG: prdata[COORD_WIDTH-1:0] = julia_imag_q;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/fti_mul.sv */
// Shared signed multiplier of the fractal iterator, full-width product, registered.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fti_mul #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic signed [COORD_WIDTH-1:0] op_a,
	input  wire logic signed [COORD_WIDTH-1:0] op_b,
	output logic signed [2*COORD_WIDTH-1:0]    prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

`default_nettype wire

/* hdl/fti_core.sv */
// Iteration core: sequencer, z registers, escape test and update around one multiplier.
// Depends on fti_pkg (states, mode codes) and instantiates fti_mul.
`timescale 1ns / 1ps
`default_nettype none

module fti_core
	import fti_pkg::*;
#(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 28,
	parameter int COUNT_WIDTH   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [MODE_W-1:0]             mode,
	input  wire logic [COUNT_WIDTH-1:0]        limit,
	input  wire logic signed [COORD_WIDTH-1:0] julia_real,
	input  wire logic signed [COORD_WIDTH-1:0] julia_imag,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] in_x,
	input  wire logic signed [COORD_WIDTH-1:0] in_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [COUNT_WIDTH-1:0]             out_count
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = 2 * W;
	// extended width for update sums, one spare bit for abs
	localparam int EW = PW + 2;
	// magnitude width must also hold the threshold 4 << 2F
	localparam int SW = (PW + 1 > 2 * FRACTION_BITS + 3) ? PW + 1 : 2 * FRACTION_BITS + 3;
	localparam logic [SW-1:0] THRESH = {{(SW-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS + 2);
	localparam logic signed [EW-1:0] SAT_MAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [EW-1:0] SAT_MIN = ~SAT_MAX;

	fti_state_t state_q, state_d;

	logic signed [W-1:0]  zr_q, zi_q, ar_q, ai_q;
	logic signed [PW-1:0] sr_q;
	logic signed [PW:0]   diff_q;
	logic                 ship_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic                 out_valid_q;
	logic [COUNT_WIDTH-1:0] res_q;

	logic signed [W-1:0]  op_a, op_b;
	logic signed [PW-1:0] prod_q;

	logic                 in_fire, res_load, escape;
	logic [SW-1:0]        mag;
	logic signed [PW:0]   diff_w;
	logic signed [EW-1:0] diff_x, cr_x, sh_r, sh_i, ar_x, ai_x, nr_w, ni_w;
	logic signed [W-1:0]  zr_next, zi_next;

	function automatic logic signed [W-1:0] sat_abs(input logic signed [EW-1:0] v,
			input logic take_abs);
		logic signed [EW-1:0] a;
		a = (take_abs && v[EW-1]) ? -v : v;
		if (a > SAT_MAX)
			return SAT_MAX[W-1:0];
		else if (a < SAT_MIN)
			return SAT_MIN[W-1:0];
		else
			return a[W-1:0];
	endfunction

	fti_mul #(.COORD_WIDTH(W)) u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_SQ_RE: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			ST_SQ_IM: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			default: begin
				op_a = zr_q;
				op_b = zi_q;
			end
		endcase
	end

	// escape test: sr_q holds zr^2, prod_q holds zi^2 in ST_CROSS
	assign mag    = {{(SW-PW){1'b0}}, sr_q} + {{(SW-PW){1'b0}}, prod_q};
	assign escape = (mag >= THRESH);

	// zr^2 - zi^2 is formed in ST_CROSS and held for the update
	assign diff_w  = {sr_q[PW-1], sr_q} - {prod_q[PW-1], prod_q};

	// update: prod_q holds zr*zi in ST_UPDATE
	assign diff_x  = {diff_q[PW], diff_q};
	assign cr_x    = {{(EW-PW){prod_q[PW-1]}}, prod_q};
	assign sh_r    = diff_x >>> FRACTION_BITS;
	assign sh_i    = cr_x >>> (FRACTION_BITS - 1);
	assign ar_x    = {{(EW-W){ar_q[W-1]}}, ar_q};
	assign ai_x    = {{(EW-W){ai_q[W-1]}}, ai_q};
	assign nr_w    = sh_r + ar_x;
	assign ni_w    = sh_i + ai_x;
	assign zr_next = sat_abs(nr_w, ship_q);
	assign zi_next = sat_abs(ni_w, ship_q);
	assign count_inc = count_q + 1'b1;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_count = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = (limit == '0) ? ST_DONE : ST_SQ_RE;
			end
			ST_SQ_RE:  state_d = ST_SQ_IM;
			ST_SQ_IM:  state_d = ST_CROSS;
			ST_CROSS:  state_d = escape ? ST_DONE : ST_UPDATE;
			ST_UPDATE: state_d = (count_inc == limit) ? ST_DONE : ST_SQ_RE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					count_q <= '0;
					ship_q  <= (mode == MODE_SHIP);
					if (mode == MODE_JULIA) begin
						// Julia starts from the swapped point
						zr_q <= in_y;
						zi_q <= in_x;
						ar_q <= julia_real;
						ai_q <= julia_imag;
					end else begin
						zr_q <= '0;
						zi_q <= '0;
						ar_q <= in_x;
						ai_q <= in_y;
					end
				end
			end
			ST_SQ_IM: sr_q <= prod_q;
			ST_CROSS: diff_q <= diff_w;
			ST_UPDATE: begin
				zr_q    <= zr_next;
				zi_q    <= zi_next;
				count_q <= count_inc;
			end
			default: ;
		endcase
		if (res_load)
			res_q <= count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// count stays below the limit while iterating
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ_RE || state_q == ST_SQ_IM || state_q == ST_CROSS ||
		 state_q == ST_UPDATE) |-> (count_q < limit))
		else $error("iteration count reached limit while still iterating");

	// an accepted point either starts iterating or finishes at once
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SQ_RE || state_q == ST_DONE))
		else $error("bad state after point accept");

	// leaving the update for done only when the limit is hit
	a_limit_exit: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_UPDATE && state_q == ST_DONE) |-> (count_q == limit))
		else $error("finished from update without reaching limit");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result register overwritten while full");

endmodule

`default_nettype wire

/* hdl/escape_time_fractal_iterator.sv */
// Top level of the escape-time fractal iterator (Mandelbrot, Julia, Burning Ship).
// Depends on fti_pkg; instantiates fti_regs and fti_core (which holds fti_mul).
//
//   channel  | signals                                         | beat moves
//   ---------+-------------------------------------------------+---------------------------
//   point    | point_valid, point_ready, point_x, point_y      | one point, signed Q4.28
//   result   | result_valid, result_ready, iteration_count     | one escape-time count
//   config   | psel, penable, pwrite, paddr, pwdata, prdata    | one register write or read
//
// One shared multiplier forms zr^2, zi^2 and zr*zi in turn (ST_SQ_RE, ST_SQ_IM,
//   ST_CROSS, with the escape test in ST_CROSS), then ST_UPDATE applies the update.
//   A zero limit goes from accept straight to the done state without iterating.
// One point is in flight at a time; point_ready is high only when the core is idle.
// A finished count sits in the result register, so the next point is accepted while it
//   waits; the core holds in its done state if the previous count is still untaken.
// Reset (arst_n low) clears the sequencer and result valid and loads mode Mandelbrot,
//   limit 64 and a zero Julia constant. No memory, no clearing pass.
// Registers sit at byte address 4*i (8*i when the coordinate is wider than 32 bits):
//   fractal_mode, iteration_limit, julia_real, julia_imag. pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_iterator
	import fti_pkg::*;
#(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 28,
	parameter int COUNT_WIDTH   = 16,
	parameter int DATA_WIDTH    = (COORD_WIDTH > 32) ? 64 : 32,
	parameter int ADDR_WIDTH    = (COORD_WIDTH > 32) ? 5 : 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ADDR_WIDTH-1:0]         paddr,
	input  wire logic [DATA_WIDTH-1:0]         pwdata,
	output logic      [DATA_WIDTH-1:0]         prdata,
	output logic                               pready,
	// point channel
	input  wire logic                          point_valid,
	output logic                               point_ready,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [COUNT_WIDTH-1:0]             iteration_count
);

	logic [MODE_W-1:0]             mode_q;
	logic [COUNT_WIDTH-1:0]        limit_q;
	logic signed [COORD_WIDTH-1:0] julia_real_q;
	logic signed [COORD_WIDTH-1:0] julia_imag_q;

	// configuration registers; the user must write them only while the core is idle, this block does not enforce it
	fti_regs #(
		.COORD_WIDTH (COORD_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH),
		.DATA_WIDTH  (DATA_WIDTH),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mode_q       (mode_q),
		.limit_q      (limit_q),
		.julia_real_q (julia_real_q),
		.julia_imag_q (julia_imag_q)
	);

	// sequencer and datapath around the shared multiplier
	fti_core #(
		.COORD_WIDTH   (COORD_WIDTH),
		.FRACTION_BITS (FRACTION_BITS),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.limit      (limit_q),
		.julia_real (julia_real_q),
		.julia_imag (julia_imag_q),
		.in_valid   (point_valid),
		.in_ready   (point_ready),
		.in_x       (point_x),
		.in_y       (point_y),
		.out_valid  (result_valid),
		.out_ready  (result_ready),
		.out_count  (iteration_count)
	);

endmodule

`default_nettype wire

/* verif/escape_time_fractal_iterator_test.sv */
// Self-checking bench for escape_time_fractal_iterator: predicts the escape-time count
// of every accepted point in a small tracker class and checks each returned beat.
// Depends on fti_pkg and the escape_time_fractal_iterator RTL.
`timescale 1ns / 1ps

import fti_pkg::*;

typedef struct {
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic [15:0]        count;
} count_due_t;

class escape_count_tracker;
	localparam int FRAC = 28;
	localparam logic signed [65:0] SAT_HI     = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO     = -66'sd2147483648;
	localparam logic signed [65:0] ESCAPE_MAG = 66'sh0400000000000000; // 4.0 at 2*FRAC

	logic [1:0]         mode;
	logic [15:0]        limit;
	logic signed [31:0] julia_re;
	logic signed [31:0] julia_im;
	count_due_t         counts_due[$];
	int                 mismatches;

	function new();
		mode       = MODE_MANDEL;
		limit      = 16'd64;
		julia_re   = '0;
		julia_im   = '0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_MODE:       mode     = value[1:0];
			REG_LIMIT:      limit    = value[15:0];
			REG_JULIA_REAL: julia_re = value;
			default:        julia_im = value;
		endcase
	endfunction

	function logic [31:0] reg_value(logic [1:0] idx);
		case (idx)
			REG_MODE:       return {30'b0, mode};
			REG_LIMIT:      return {16'b0, limit};
			REG_JULIA_REAL: return julia_re;
			default:        return julia_im;
		endcase
	endfunction

	function logic signed [31:0] clamp(logic signed [65:0] v);
		if (v > SAT_HI)
			return 32'sh7FFF_FFFF;
		if (v < SAT_LO)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function logic [15:0] escape_count(logic signed [31:0] px, logic signed [31:0] py);
		logic signed [31:0] zr, zi, ar, ai;
		logic signed [63:0] sr, si, cr;
		logic signed [65:0] mag, diff, nr, ni;
		int unsigned        n;
		zr = '0;
		zi = '0;
		ar = px;
		ai = py;
		// Julia seeds z with the swapped point and adds the constant instead
		if (mode == MODE_JULIA) begin
			zr = py;
			zi = px;
			ar = julia_re;
			ai = julia_im;
		end
		n = 0;
		while (n < limit) begin
			sr  = zr * zr;
			si  = zi * zi;
			mag = sr + si;
			if (mag >= ESCAPE_MAG)
				break;
			cr   = zr * zi;
			diff = sr - si;
			nr   = (diff >>> FRAC) + ar;
			ni   = (cr >>> (FRAC - 1)) + ai;
			if (mode == MODE_SHIP) begin
				if (nr < 0)
					nr = -nr;
				if (ni < 0)
					ni = -ni;
			end
			zr = clamp(nr);
			zi = clamp(ni);
			n++;
		end
		return n[15:0];
	endfunction

	function void note_point(logic signed [31:0] px, logic signed [31:0] py);
		count_due_t e;
		e.x     = px;
		e.y     = py;
		e.count = escape_count(px, py);
		counts_due.push_back(e);
	endfunction

	function int pending();
		return counts_due.size();
	endfunction

	task report(string msg);
		mismatches++;
		$display("ERROR: %s", msg);
	endtask

	task check_count(logic [15:0] got);
		count_due_t e;
		if (counts_due.size() == 0) begin
			report($sformatf("count %0d arrived with no point outstanding", got));
			return;
		end
		e = counts_due.pop_front();
		if (got !== e.count)
			report($sformatf("point (%h, %h) mode %0d limit %0d: count %0d, predicted %0d",
				e.x, e.y, mode, limit, got, e.count));
	endtask

	task check_drained();
		if (counts_due.size() != 0)
			report($sformatf("%0d counts never arrived", counts_due.size()));
	endtask
endclass

module escape_time_fractal_iterator_test;

	localparam int ONE_Q           = 268435456;     // 1.0 in Q4.28
	localparam int SETTLE_CYCLES   = 8;
	// Longest legal quiet stretch is one point at limit 65535
	localparam int WATCHDOG_CYCLES = 1100000;
	localparam int PHASE_POINTS    = 80;

	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               point_valid;
	logic               point_ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic               result_valid;
	logic               result_ready;
	logic [15:0]        iteration_count;

	escape_count_tracker tracker;

	int idle_pct;      // chance in 100 that the point side skips a cycle
	int stall_pct;     // chance in 100 that the result side holds off
	int quiet_cycles;  // cycles since the last beat on any port

	logic [1:0] reg_order[4] = '{REG_MODE, REG_LIMIT, REG_JULIA_REAL, REG_JULIA_IMAG};

	escape_time_fractal_iterator u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.point_valid     (point_valid),
		.point_ready     (point_ready),
		.point_x         (point_x),
		.point_y         (point_y),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.iteration_count (iteration_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: everything is sampled at the rising edge, the stimulus moves on the
	// falling edge, so a beat is seen exactly once. The count is checked before a point
	// taken on the same edge is noted; the count always belongs to an older point.
	always @(posedge clk) begin
		if (result_valid && result_ready)
			tracker.check_count(iteration_count);
		if (point_valid && point_ready)
			tracker.note_point(point_x, point_y);
		if ((result_valid && result_ready) || (point_valid && point_ready) ||
			(psel && penable && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Watchdog: a hung handshake ends the run
	initial begin
		quiet_cycles = 0;
		@(posedge clk);
		while (quiet_cycles < WATCHDOG_CYCLES)
			@(posedge clk);
		$display("escape_time_fractal_iterator: mismatch");
		$finish;
	end

	// Result side: ready is redrawn every cycle, one assignment per falling edge
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Mostly points in the interesting window [-2.5, 2.5], some raw 32-bit patterns
	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(99) < 85)
			return $urandom_range(0, 5 * ONE_Q) - 5 * ONE_Q / 2;
		return $urandom();
	endfunction

	// Called and returns on a falling edge. Valid is left high after the beat; the next
	// call (or pause_points) replaces it in the following step, never twice in one step.
	task automatic drive_point(input logic signed [31:0] x, input logic signed [31:0] y);
		while ($urandom_range(99) < idle_pct) begin
			point_valid <= 1'b0;
			@(negedge clk);
		end
		point_valid <= 1'b1;
		point_x     <= x;
		point_y     <= y;
		do
			@(posedge clk);
		while (!(point_valid && point_ready));
		@(negedge clk);
	endtask

	// Hold the point side until every count has come back, then let the core settle
	task automatic pause_points();
		point_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One APB transfer: setup, access, then psel released before the next one
	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_readback(input logic [1:0] idx);
		logic [31:0] rd;
		apb_access(1'b0, idx, 32'h0, rd);
		if (rd !== tracker.reg_value(idx))
			tracker.report($sformatf("register %0d reads %h, holds %h", idx, rd,
				tracker.reg_value(idx)));
	endtask

	// Drain, then write and read back all four registers
	task automatic apply_setting(input logic [1:0] mode, input logic [15:0] limit,
		input logic signed [31:0] jre, input logic signed [31:0] jim);
		logic [31:0] vals[4];
		logic [31:0] rd;
		vals = '{{30'b0, mode}, {16'b0, limit}, jre, jim};
		pause_points();
		foreach (reg_order[i]) begin
			apb_access(1'b1, reg_order[i], vals[i], rd);
			tracker.set_reg(reg_order[i], vals[i]);
			check_readback(reg_order[i]);
		end
	endtask

	int idle_by_phase[4]  = '{0, 84, 0, 24};
	int stall_by_phase[4] = '{0, 0, 84, 24};

	initial begin
		logic [1:0]  rmode;
		logic [15:0] rlimit;
		logic [31:0] rjre, rjim;
		tracker     = new();
		idle_pct    = 0;
		stall_pct   = 0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		point_valid = 1'b0;
		point_x     = '0;
		point_y     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: Mandelbrot, limit 64, zero constant
		foreach (reg_order[i])
			check_readback(reg_order[i]);

		// Directed: Mandelbrot at reset setting, coordinate extremes and known orbits
		drive_point(32'sd0, 32'sd0);                   // in the set, runs to the limit
		drive_point(COORD_MIN, COORD_MIN);
		drive_point(COORD_MAX, COORD_MAX);             // escapes after one iteration
		drive_point(COORD_MIN, COORD_MAX);
		drive_point(2 * ONE_Q, 32'sd0);                // lands exactly on |z|^2 = 4
		drive_point(-ONE_Q, 32'sd0);                   // period-two orbit
		drive_point(ONE_Q / 4, 32'sd0);                // cusp, converges slowly and runs to the limit
		drive_point(-ONE_Q * 3 / 4, ONE_Q / 10);

		// Zero limit gives a zero count whatever the point
		apply_setting(MODE_MANDEL, 16'd0, 32'sd0, 32'sd0);
		drive_point(32'sd0, 32'sd0);
		drive_point(COORD_MAX, COORD_MIN);

		// Unused mode code runs as Mandelbrot
		apply_setting(2'd3, 16'd64, 32'sd0, 32'sd0);
		drive_point(32'sd0, 32'sd0);
		drive_point(-ONE_Q * 3 / 2, ONE_Q / 2);

		// Julia with a classic constant; the point is swapped into z
		apply_setting(MODE_JULIA, 16'd64, -ONE_Q * 4 / 5, ONE_Q / 1000 * 156);
		drive_point(32'sd0, 32'sd0);
		drive_point(ONE_Q / 10 * 19, 32'sd0);

		// Julia with extreme constants: the update saturates inside the escape radius
		apply_setting(MODE_JULIA, 16'd64, COORD_MAX, COORD_MIN);
		drive_point(32'sd0, 32'sd0);
		drive_point(32'sd0, ONE_Q / 10 * 19);

		// Burning Ship: abs of the most negative sum saturates to the top
		apply_setting(MODE_SHIP, 16'd64, 32'sd0, 32'sd0);
		drive_point(COORD_MIN, 32'sd0);
		drive_point(-ONE_Q * 7 / 4, -ONE_Q / 100 * 3);
		drive_point(32'sd0, 32'sd0);

		// Full limit: one point runs all 65535 iterations, one escapes after a single iteration
		apply_setting(MODE_MANDEL, 16'hFFFF, 32'sd0, 32'sd0);
		drive_point(32'sd0, 32'sd0);
		drive_point(COORD_MAX, 32'sd0);

		// Random part: four idling phases, four register settings in each.
		// Every setting change drains the core first, so the point side pauses there.
		foreach (idle_by_phase[ph]) begin
			for (int s = 0; s < 4; s++) begin
				rmode = 2'($urandom_range(3));
				case ($urandom_range(9))
					0:       rlimit = 16'd0;
					1:       rlimit = 16'($urandom_range(100, 300));
					default: rlimit = 16'($urandom_range(1, 72));
				endcase
				if ($urandom_range(3) == 0) begin
					rjre = $urandom();
					rjim = $urandom();
				end else begin
					rjre = $urandom_range(0, 5 * ONE_Q / 2) - 5 * ONE_Q / 4;
					rjim = $urandom_range(0, 5 * ONE_Q / 2) - 5 * ONE_Q / 4;
				end
				apply_setting(rmode, rlimit, rjre, rjim);
				idle_pct  = idle_by_phase[ph];
				stall_pct = stall_by_phase[ph];
				repeat (PHASE_POINTS)
					drive_point(rand_coord(), rand_coord());
			end
		end

		// Wind down: every count back, then let the core settle
		idle_pct  = 0;
		stall_pct = 0;
		pause_points();
		tracker.check_drained();
		if (tracker.mismatches == 0)
			$display("escape_time_fractal_iterator: match");
		else
			$display("escape_time_fractal_iterator: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
hdl/fti_pkg.sv
hdl/fti_regs.sv
hdl/fti_mul.sv
hdl/fti_core.sv
hdl/escape_time_fractal_iterator.sv
verif/escape_time_fractal_iterator_test.sv
